### rtl/core/lsem_pkg.sv
// lsem_pkg: shared constants, widths and types of the Laplacian sign edge map.
// No dependencies; imported by lsem_pos, lsem_kernel and laplacian_sign_edge_map_core.
`timescale 1ns / 1ps

package lsem_pkg;

  localparam int MAX_WIDTH   = 4096;              // line store depth, power of two
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int PIX_W       = 8;
  localparam int IMG_WIDTH_W = 13;
  localparam int IMG_HEIGHT_W = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int SUM_W       = 11;                // holds -1020..1020

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = 13'd280;
  localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd280;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  typedef struct packed {
    logic [COL_W-1:0] idx;
    logic             emit;
    logic             last;
  } pos_t;

endpackage

### rtl/core/lsem_ram.sv
// lsem_ram: generic single-write, single-read RAM with registered read data.
// Read data holds while the read enable is low. No package dependency.
`timescale 1ns / 1ps

module lsem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/lsem_pos.sv
// lsem_pos: column/row position counters and per-beat emit / frame-end decode.
// Depends on lsem_pkg.
`timescale 1ns / 1ps

module lsem_pos import lsem_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    frame_start,
  input  logic [IMG_WIDTH_W-1:0]  image_width,
  input  logic [IMG_HEIGHT_W-1:0] image_height,
  output pos_t                    pos
);

  logic [COL_W-1:0]        column_count, column_next, col_cur, col_last;
  logic [IMG_HEIGHT_W-1:0] row_count, row_next, row_cur, row_last;
  logic                    row_end, frame_last;

  always_comb begin
    if (image_width < IMG_WIDTH_W'(3)) begin
      col_last = COL_W'(2);
    end else if (image_width > IMG_WIDTH_W'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(image_width - IMG_WIDTH_W'(1));
    end
    if (image_height < IMG_HEIGHT_W'(3)) begin
      row_last = IMG_HEIGHT_W'(2);
    end else begin
      row_last = image_height - IMG_HEIGHT_W'(1);
    end
  end

  assign col_cur    = frame_start ? '0 : column_count;
  assign row_cur    = frame_start ? '0 : row_count;
  assign row_end    = col_cur >= col_last;
  assign frame_last = row_end && (row_cur >= row_last);

  always_comb begin
    column_next = col_cur + COL_W'(1);
    row_next    = row_cur;
    if (row_end) begin
      column_next = '0;
      row_next    = frame_last ? '0 : row_cur + IMG_HEIGHT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (step) begin
      column_count <= column_next;
      row_count    <= row_next;
    end
  end

  assign pos.idx  = col_cur;
  assign pos.emit = (row_cur >= IMG_HEIGHT_W'(2)) && (col_cur >= COL_W'(2));
  assign pos.last = frame_last;

endmodule

### rtl/core/lsem_kernel.sv
// lsem_kernel: 3x3 window columns and the 4-neighbor Laplacian sign decision.
// Depends on lsem_pkg.
`timescale 1ns / 1ps

module lsem_kernel import lsem_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [PIX_W-1:0] up,
  input  logic [PIX_W-1:0] mid,
  input  logic [PIX_W-1:0] pix,
  output logic             positive
);

  // newest column of top and bottom rows, last two columns of the middle row
  logic [PIX_W-1:0] top_c, mid_c1, mid_c2, bot_c;
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_c  <= '0;
      mid_c1 <= '0;
      mid_c2 <= '0;
      bot_c  <= '0;
    end else if (step) begin
      top_c  <= up;
      mid_c1 <= mid_c2;
      mid_c2 <= mid;
      bot_c  <= pix;
    end
  end

  // window after the shift: up=top_c, down=bot_c, left=mid_c1, right=mid, center=mid_c2
  assign sum = SUM_W'(top_c) + SUM_W'(bot_c) + SUM_W'(mid_c1) + SUM_W'(mid)
             - (SUM_W'(mid_c2) << 2);

  assign positive = !sum[SUM_W-1] && (sum != '0);

endmodule

### rtl/core/laplacian_sign_edge_map_core.sv
// laplacian_sign_edge_map_core: streaming 4-neighbor Laplacian sign map.
// Depends on lsem_pkg, lsem_ram, lsem_pos, lsem_kernel.
//
//  port group   dir  handshake            payload
//  in           in   in_valid / in_ready  pixel_value, frame_start
//  out          out  out_valid/out_ready  edge_value, frame_end
//  cfg          in   cfg_we (no wait)     cfg_index, cfg_data
//
// One pixel per clock sustained while the output is not stalled. Each pixel beat
// passes the registered read of the two line store RAMs, then the kernel
// compare into the output register.
// Reset clears counters, window and valid flags; line stores are not cleared.
// A stalled output holds one result while one more pixel waits in the RAM stage.
`timescale 1ns / 1ps

module laplacian_sign_edge_map_core import lsem_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PIX_W-1:0]       pixel_value,
  input  logic                   frame_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIX_W-1:0]       edge_value,
  output logic                   frame_end,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;

  logic             accept, s1_move;
  pos_t             pos;
  logic             s1_valid, s1_emit, s1_last, s1_hit;
  logic [COL_W-1:0] s1_idx;
  logic [PIX_W-1:0] s1_pix, fwd_up, fwd_mid;
  logic [PIX_W-1:0] ram_up, ram_mid, up_eff, mid_eff;
  logic             positive;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  lsem_pos u_pos (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .frame_start  (frame_start),
    .image_width  (image_width),
    .image_height (image_height),
    .pos          (pos)
  );

  // back-to-back beats at the same column bypass the RAM write still in flight
  assign up_eff  = s1_hit ? fwd_up  : ram_up;
  assign mid_eff = s1_hit ? fwd_mid : ram_mid;

  lsem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_upper (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_idx),
    .wdata (mid_eff),
    .re    (accept),
    .raddr (pos.idx),
    .rdata (ram_up)
  );

  lsem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_middle (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_idx),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (pos.idx),
    .rdata (ram_mid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx  <= pos.idx;
      s1_emit <= pos.emit;
      s1_last <= pos.last;
      s1_pix  <= pixel_value;
      s1_hit  <= s1_valid && (pos.idx == s1_idx);
      fwd_up  <= mid_eff;
      fwd_mid <= s1_pix;
    end
  end

  lsem_kernel u_kernel (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_move),
    .up       (up_eff),
    .mid      (mid_eff),
    .pix      (s1_pix),
    .positive (positive)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_emit) begin
      edge_value <= positive ? EDGE_ON : EDGE_OFF;
      frame_end  <= s1_last;
    end
  end

  a_start_col0: assert property (@(posedge clk) disable iff (rst)
    accept && frame_start |=> s1_valid && (s1_idx == '0) && !s1_emit)
    else $error("frame start did not restart the column");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last |-> s1_emit)
    else $error("frame end on a border pixel");

  a_edge_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (edge_value == EDGE_ON) || (edge_value == EDGE_OFF))
    else $error("edge value not a binary code");

  a_hit_same_col: assert property (@(posedge clk) disable iff (rst)
    accept && s1_valid && (pos.idx != s1_idx) |=> !s1_hit)
    else $error("bypass taken for a different column");

endmodule
